// ----- design/adhesion_ode_euler_step_macros.svh -----
// Assertion macros shared by the integrator modules.
`ifndef ADHESION_ODE_EULER_STEP_MACROS_SVH
`define ADHESION_ODE_EULER_STEP_MACROS_SVH

`ifndef SYNTHESIS

`define AOE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define AOE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AOE_ASSERT_IMPL(label, clk, rst, ante, cons)

`define AOE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/aoe_pkg.sv -----
// Shared types, constants and the micro-program of the Euler integrator.
`timescale 1ns / 1ps

package aoe_pkg;

  localparam int STATE_WIDTH_DEF = 48;
  localparam int AMOUNT_WIDTH    = 48;
  localparam int RATE_WIDTH      = 47;
  localparam int STEP_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int FRAC_BITS       = 32;
  localparam int DIGIT_WIDTH     = 32;
  localparam int MAG_DIGITS      = 2;
  localparam int MAG_WIDTH       = DIGIT_WIDTH * MAG_DIGITS;
  localparam int PROD_WIDTH      = 2 * MAG_WIDTH;
  localparam int PC_WIDTH        = 5;

  // Q16.32 constants
  localparam logic [63:0] FX_DT   = 64'd429497;
  localparam logic [63:0] FX_ET   = 64'd429496729600;
  localparam logic [63:0] FX_PT   = 64'd1439415340;
  localparam logic [63:0] FX_KM   = 64'd42949673;
  localparam logic [63:0] FX_K2   = 64'd128849019;
  localparam logic [63:0] INIT_EB = 64'd429496729600;
  localparam logic [63:0] INIT_B  = 64'd150799312994;
  localparam logic [63:0] INIT_C  = 64'd1431655765;

  // register defaults
  localparam logic [RATE_WIDTH-1:0] THRESHOLD_CT_RST = 47'd214748364800;
  localparam logic [RATE_WIDTH-1:0] RELEASE_RATE_RST = 47'd8589934592;
  localparam logic [RATE_WIDTH-1:0] DETACH_RATE_RST  = 47'd429496730;
  localparam logic [STEP_WIDTH-1:0] WINDOW_START_RST = 16'd4000;
  localparam logic [STEP_WIDTH-1:0] WINDOW_END_RST   = 16'd8000;
  localparam logic [STEP_WIDTH-1:0] OUT_INTERVAL_RST = 16'd100;
  localparam logic [RATE_WIDTH-1:0] BIND_RATE_RST    = 47'd429496729600;
  localparam logic [RATE_WIDTH-1:0] UNBIND_RATE_RST  = 47'd81604378624;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_THRESHOLD_CT    = 3'd0,
    REG_RELEASE_RATE    = 3'd1,
    REG_DETACH_RATE     = 3'd2,
    REG_WINDOW_START    = 3'd3,
    REG_WINDOW_END      = 3'd4,
    REG_OUTPUT_INTERVAL = 3'd5,
    REG_BIND_RATE       = 3'd6,
    REG_UNBIND_RATE     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_KP, SRC_KMR, SRC_A, SRC_D, SRC_PT, SRC_KM, SRC_K2,
    SRC_ET, SRC_DT, SRC_EC, SRC_EB, SRC_B, SRC_C, SRC_T0, SRC_T1,
    SRC_BIND, SRC_UNB, SRC_DEB, SRC_DB, SRC_DEC, SRC_DC
  } src_t;

  typedef enum logic [3:0] {
    DST_T0, DST_T1, DST_BIND, DST_UNB, DST_DEB, DST_DB, DST_DEC, DST_DC,
    DST_EC, DST_EB, DST_B, DST_C
  } dst_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_BRANCH, SEQ_JUMP, SEQ_END
  } seq_t;

  typedef struct packed {
    op_t  op;
    dst_t dst;
    src_t sa;
    src_t sb;
    seq_t seq;
  } uop_t;

  localparam logic [PC_WIDTH-1:0] PC_RELEASE = 5'd8;
  localparam logic [PC_WIDTH-1:0] PC_REBIND  = 5'd14;
  localparam logic [PC_WIDTH-1:0] PC_UPDATE  = 5'd24;

  // One Euler step: shared rate terms, then release or rebinding branch,
  // then the four dt-scaled state updates.
  function automatic uop_t uop_rom(input logic [PC_WIDTH-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_MUL, DST_T0,   SRC_KP,   SRC_B,    SEQ_NEXT};
      5'd1:  u = '{OP_SUB, DST_T1,   SRC_PT,   SRC_C,    SEQ_NEXT};
      5'd2:  u = '{OP_MUL, DST_BIND, SRC_T0,   SRC_T1,   SEQ_NEXT};
      5'd3:  u = '{OP_MUL, DST_UNB,  SRC_KMR,  SRC_C,    SEQ_NEXT};
      5'd4:  u = '{OP_MUL, DST_DEC,  SRC_D,    SRC_EB,   SEQ_NEXT};
      5'd5:  u = '{OP_MUL, DST_T0,   SRC_K2,   SRC_C,    SEQ_NEXT};
      5'd6:  u = '{OP_SUB, DST_T1,   SRC_BIND, SRC_UNB,  SEQ_NEXT};
      5'd7:  u = '{OP_SUB, DST_DC,   SRC_T1,   SRC_T0,   SEQ_BRANCH};
      // release
      5'd8:  u = '{OP_ADD, DST_T0,   SRC_A,    SRC_D,    SEQ_NEXT};
      5'd9:  u = '{OP_MUL, DST_T1,   SRC_T0,   SRC_EB,   SEQ_NEXT};
      5'd10: u = '{OP_SUB, DST_DEB,  SRC_ZERO, SRC_T1,   SEQ_NEXT};
      5'd11: u = '{OP_SUB, DST_T0,   SRC_T1,   SRC_BIND, SEQ_NEXT};
      5'd12: u = '{OP_ADD, DST_T0,   SRC_T0,   SRC_UNB,  SEQ_NEXT};
      5'd13: u = '{OP_ADD, DST_DB,   SRC_T0,   SRC_KM,   SEQ_JUMP};
      // rebinding
      5'd14: u = '{OP_SUB, DST_T0,   SRC_ET,   SRC_EC,   SEQ_NEXT};
      5'd15: u = '{OP_SUB, DST_T0,   SRC_T0,   SRC_EB,   SEQ_NEXT};
      5'd16: u = '{OP_MUL, DST_T0,   SRC_ET,   SRC_T0,   SEQ_NEXT};
      5'd17: u = '{OP_MUL, DST_T1,   SRC_T0,   SRC_B,    SEQ_NEXT};
      5'd18: u = '{OP_SUB, DST_DEB,  SRC_T1,   SRC_DEC,  SEQ_NEXT};
      5'd19: u = '{OP_SUB, DST_T0,   SRC_ZERO, SRC_T1,   SEQ_NEXT};
      5'd20: u = '{OP_ADD, DST_T0,   SRC_T0,   SRC_DEC,  SEQ_NEXT};
      5'd21: u = '{OP_SUB, DST_T0,   SRC_T0,   SRC_BIND, SEQ_NEXT};
      5'd22: u = '{OP_ADD, DST_T0,   SRC_T0,   SRC_UNB,  SEQ_NEXT};
      5'd23: u = '{OP_ADD, DST_DB,   SRC_T0,   SRC_KM,   SEQ_NEXT};
      // state update
      5'd24: u = '{OP_MUL, DST_T0,   SRC_DT,   SRC_DEC,  SEQ_NEXT};
      5'd25: u = '{OP_ADD, DST_EC,   SRC_EC,   SRC_T0,   SEQ_NEXT};
      5'd26: u = '{OP_MUL, DST_T0,   SRC_DT,   SRC_DEB,  SEQ_NEXT};
      5'd27: u = '{OP_ADD, DST_EB,   SRC_EB,   SRC_T0,   SEQ_NEXT};
      5'd28: u = '{OP_MUL, DST_T0,   SRC_DT,   SRC_DB,   SEQ_NEXT};
      5'd29: u = '{OP_ADD, DST_B,    SRC_B,    SRC_T0,   SEQ_NEXT};
      5'd30: u = '{OP_MUL, DST_T0,   SRC_DT,   SRC_DC,   SEQ_NEXT};
      5'd31: u = '{OP_ADD, DST_C,    SRC_C,    SRC_T0,   SEQ_END};
      default: u = '{OP_ADD, DST_T0, SRC_ZERO, SRC_ZERO, SEQ_END};
    endcase
    return u;
  endfunction

endpackage

// ----- design/aoe_alu.sv -----
// Shared saturating add/subtract and iterative Q16.32 multiply unit.
`timescale 1ns / 1ps
`include "adhesion_ode_euler_step_macros.svh"

module aoe_alu #(
  parameter int STATE_WIDTH = aoe_pkg::STATE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  aoe_pkg::alu_ctl_t             ctl,
  input  logic signed [STATE_WIDTH-1:0] a,
  input  logic signed [STATE_WIDTH-1:0] b,
  output logic                          done,
  output logic signed [STATE_WIDTH-1:0] y
);
  import aoe_pkg::*;

  localparam int W       = STATE_WIDTH;
  localparam int Q_WIDTH = PROD_WIDTH - FRAC_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2:0] K_LAST = 3'(MAG_DIGITS * MAG_DIGITS);
  localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_MUL  = 3'b010,
    A_FIN  = 3'b100
  } alu_state_t;

  alu_state_t              alu_state;
  logic [MAG_WIDTH-1:0]    ma;
  logic [MAG_WIDTH-1:0]    mb;
  logic                    neg;
  logic [2:0]              k;
  logic [2*DIGIT_WIDTH-1:0] pp;
  logic [1:0]              pw;
  logic [PROD_WIDTH-1:0]   acc;

  logic [W-1:0]            a_mag;
  logic [W-1:0]            b_mag;
  logic signed [W:0]       ea;
  logic signed [W:0]       eb;
  logic signed [W:0]       as_sum;
  logic signed [W-1:0]     as_y;
  logic [DIGIT_WIDTH-1:0]  dig_a;
  logic [DIGIT_WIDTH-1:0]  dig_b;
  logic [2*DIGIT_WIDTH-1:0] pp_next;
  logic [PROD_WIDTH-1:0]   pp_shift;
  logic [PROD_WIDTH-1:0]   rsum;
  logic [Q_WIDTH-1:0]      q;
  logic                    q_sat;
  logic signed [W-1:0]     qm;
  logic signed [W-1:0]     mul_y;

  assign a_mag = a[W-1] ? W'(-a) : W'(a);
  assign b_mag = b[W-1] ? W'(-b) : W'(b);

  assign ea     = {a[W-1], a};
  assign eb     = {b[W-1], b};
  assign as_sum = (ctl.op == OP_SUB) ? (ea - eb) : (ea + eb);
  assign as_y   = (as_sum[W] != as_sum[W-1]) ? (as_sum[W] ? VMIN : VMAX) : as_sum[W-1:0];

  // k[1] walks the digits of a, k[0] those of b
  assign dig_a   = k[1] ? ma[MAG_WIDTH-1:DIGIT_WIDTH] : ma[DIGIT_WIDTH-1:0];
  assign dig_b   = k[0] ? mb[MAG_WIDTH-1:DIGIT_WIDTH] : mb[DIGIT_WIDTH-1:0];
  assign pp_next = 64'(dig_a) * 64'(dig_b);

  always_comb begin
    case (pw)
      2'd0:    pp_shift = {{(2*DIGIT_WIDTH){1'b0}}, pp};
      2'd1:    pp_shift = {{DIGIT_WIDTH{1'b0}}, pp, {DIGIT_WIDTH{1'b0}}};
      2'd2:    pp_shift = {pp, {(2*DIGIT_WIDTH){1'b0}}};
      default: pp_shift = '0;
    endcase
  end

  // round magnitude to nearest, ties away from zero, then saturate
  assign rsum  = acc + ROUND_HALF;
  assign q     = rsum[PROD_WIDTH-1:FRAC_BITS];
  assign q_sat = |q[Q_WIDTH-1:W-1];
  assign qm    = $signed(q[W-1:0]);
  assign mul_y = q_sat ? (neg ? VMIN : VMAX) : (neg ? -qm : qm);

  always_ff @(posedge clk) begin
    if (rst) begin
      alu_state <= A_IDLE;
      done      <= 1'b0;
      k         <= '0;
    end else begin
      done <= 1'b0;
      unique case (alu_state)
        A_IDLE: begin
          if (ctl.start) begin
            unique case (ctl.op)
              OP_ADD, OP_SUB: begin
                y    <= as_y;
                done <= 1'b1;
              end
              OP_MUL: begin
                ma        <= MAG_WIDTH'(a_mag);
                mb        <= MAG_WIDTH'(b_mag);
                neg       <= a[W-1] ^ b[W-1];
                acc       <= '0;
                k         <= '0;
                alu_state <= A_MUL;
              end
              default: begin
                y    <= '0;
                done <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          // product of step k registered, summed in the next cycle
          if (k != K_LAST) begin
            pp <= pp_next;
            pw <= {1'b0, k[1]} + {1'b0, k[0]};
          end
          if (k != 3'd0) begin
            acc <= acc + pp_shift;
          end
          k <= k + 3'd1;
          if (k == K_LAST) begin
            alu_state <= A_FIN;
          end
        end
        A_FIN: begin
          y         <= mul_y;
          done      <= 1'b1;
          alu_state <= A_IDLE;
        end
        default: alu_state <= A_IDLE;
      endcase
    end
  end

  `AOE_ASSERT_IMPL(a_alu_start_idle, clk, rst, ctl.start, alu_state == A_IDLE)
  `AOE_ASSERT_NEXT(a_alu_done_pulse, clk, rst, done, !done)
  `AOE_ASSERT_NEXT(a_alu_mul_sign, clk, rst, alu_state == A_FIN && !neg, !y[W-1])

endmodule

// ----- design/aoe_rem.sv -----
// Bit-serial remainder of the step index by the output interval.
`timescale 1ns / 1ps

module aoe_rem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [aoe_pkg::STEP_WIDTH-1:0] dividend,
  input  logic [aoe_pkg::STEP_WIDTH-1:0] divisor,
  output logic                           done,
  output logic                           zero
);
  import aoe_pkg::*;

  localparam int CNT_WIDTH = $clog2(STEP_WIDTH + 1);

  logic                  busy;
  logic                  have;
  logic [CNT_WIDTH-1:0]  cnt;
  logic [STEP_WIDTH-1:0] qs;
  logic [STEP_WIDTH-1:0] r;
  logic [STEP_WIDTH:0]   rs;
  logic [STEP_WIDTH:0]   diff;
  logic                  ge;

  assign rs   = {r, qs[STEP_WIDTH-1]};
  assign ge   = rs >= {1'b0, divisor};
  assign diff = rs - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      have <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      qs   <= dividend;
      r    <= '0;
      cnt  <= CNT_WIDTH'(STEP_WIDTH);
      busy <= 1'b1;
      have <= 1'b0;
    end else if (busy) begin
      // one quotient bit a cycle, restoring
      r   <= ge ? diff[STEP_WIDTH-1:0] : rs[STEP_WIDTH-1:0];
      qs  <= {qs[STEP_WIDTH-2:0], 1'b0};
      cnt <= cnt - CNT_WIDTH'(1);
      if (cnt == CNT_WIDTH'(1)) begin
        busy <= 1'b0;
        have <= 1'b1;
      end
    end
  end

  assign done = have;
  assign zero = (r == '0);

endmodule

// ----- design/adhesion_ode_euler_step.sv -----
// Top level: forward Euler integrator for a four-variable cadherin adhesion model.
// One input word runs one step (release or rebinding branch); no new word is taken
// until the step ends. A result word is registered at the end when the step index is a
// multiple of the output interval. The pace is set by the shared ALU (a product is four
// 32x32 digit products); one step runs 22 (release) or 26 (rebinding) ops.
// Reset restores register defaults and the initial amounts; no clearing pass.
`timescale 1ns / 1ps
`include "adhesion_ode_euler_step_macros.svh"

module adhesion_ode_euler_step #(
  parameter int STATE_WIDTH = aoe_pkg::STATE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [aoe_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [aoe_pkg::RATE_WIDTH-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   reinit,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [aoe_pkg::STEP_WIDTH-1:0]         step_index,
  output logic signed [aoe_pkg::AMOUNT_WIDTH-1:0] bound_amount,
  output logic signed [aoe_pkg::AMOUNT_WIDTH-1:0] complex_amount,
  output logic signed [aoe_pkg::AMOUNT_WIDTH-1:0] cleaved_amount,
  output logic signed [aoe_pkg::AMOUNT_WIDTH-1:0] free_amount
);
  import aoe_pkg::*;

  localparam int W = STATE_WIDTH;
  localparam logic [63:0] VMAX64 = (64'd1 << (W - 1)) - 64'd1;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  function automatic logic signed [W-1:0] clamp_pos(input logic [63:0] v);
    logic signed [W-1:0] r;
    if (v > VMAX64) r = VMAX;
    else            r = v[W-1:0];
    return r;
  endfunction

  function automatic logic [AMOUNT_WIDTH-1:0] to_amount(input logic signed [W-1:0] v);
    logic signed [63:0] x;
    x = 64'(v);
    return x[AMOUNT_WIDTH-1:0];
  endfunction

  localparam logic signed [W-1:0] DT_C      = clamp_pos(FX_DT);
  localparam logic signed [W-1:0] ET_C      = clamp_pos(FX_ET);
  localparam logic signed [W-1:0] PT_C      = clamp_pos(FX_PT);
  localparam logic signed [W-1:0] KM_C      = clamp_pos(FX_KM);
  localparam logic signed [W-1:0] K2_C      = clamp_pos(FX_K2);
  localparam logic signed [W-1:0] INIT_EB_C = clamp_pos(INIT_EB);
  localparam logic signed [W-1:0] INIT_B_C  = clamp_pos(INIT_B);
  localparam logic signed [W-1:0] INIT_C_C  = clamp_pos(INIT_C);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_ISSUE  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  // configuration
  logic [RATE_WIDTH-1:0] threshold_ct;
  logic [RATE_WIDTH-1:0] release_rate;
  logic [RATE_WIDTH-1:0] detach_rate;
  logic [STEP_WIDTH-1:0] window_start;
  logic [STEP_WIDTH-1:0] window_end;
  logic [STEP_WIDTH-1:0] output_interval;
  logic [RATE_WIDTH-1:0] bind_rate;
  logic [RATE_WIDTH-1:0] unbind_rate;

  // model state and scratch
  logic signed [W-1:0]   cleaved_e;
  logic signed [W-1:0]   bound_e;
  logic signed [W-1:0]   free_b;
  logic signed [W-1:0]   complex_c;
  logic [STEP_WIDTH-1:0] step_counter;
  logic signed [W-1:0]   t0;
  logic signed [W-1:0]   t1;
  logic signed [W-1:0]   bind_r;
  logic signed [W-1:0]   unb_r;
  logic signed [W-1:0]   deb_r;
  logic signed [W-1:0]   db_r;
  logic signed [W-1:0]   dec_r;
  logic signed [W-1:0]   dc_r;
  logic                  d_active;
  logic [PC_WIDTH-1:0]   pc;

  logic signed [W-1:0]   ct_c;
  logic signed [W-1:0]   a_c;
  logic signed [W-1:0]   d_c;
  logic signed [W-1:0]   kp_c;
  logic signed [W-1:0]   kmr_c;
  logic                  release_mode;
  logic [STEP_WIDTH-1:0] interval_eff;
  uop_t                  uop;
  alu_ctl_t              alu_ctl;
  logic signed [W-1:0]   alu_a;
  logic signed [W-1:0]   alu_b;
  logic                  alu_done;
  logic signed [W-1:0]   alu_y;
  logic                  rem_done;
  logic                  rem_zero;
  logic                  step_done;
  logic                  load_out;

  assign ct_c  = clamp_pos(64'(threshold_ct));
  assign a_c   = clamp_pos(64'(release_rate));
  assign d_c   = d_active ? clamp_pos(64'(detach_rate)) : '0;
  assign kp_c  = clamp_pos(64'(bind_rate));
  assign kmr_c = clamp_pos(64'(unbind_rate));

  assign release_mode = free_b > ct_c;
  assign interval_eff = (output_interval == '0) ? STEP_WIDTH'(1) : output_interval;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // when this step emits a word, hold in finish while the previous word is still stalled
  assign step_done = (state == S_FINISH) && rem_done && (!rem_zero || !out_valid || !out_stall);
  assign load_out  = step_done && rem_zero;

  assign uop = uop_rom(pc);

  function automatic logic signed [W-1:0] src_value(input src_t s);
    logic signed [W-1:0] v;
    unique case (s)
      SRC_ZERO: v = '0;
      SRC_KP:   v = kp_c;
      SRC_KMR:  v = kmr_c;
      SRC_A:    v = a_c;
      SRC_D:    v = d_c;
      SRC_PT:   v = PT_C;
      SRC_KM:   v = KM_C;
      SRC_K2:   v = K2_C;
      SRC_ET:   v = ET_C;
      SRC_DT:   v = DT_C;
      SRC_EC:   v = cleaved_e;
      SRC_EB:   v = bound_e;
      SRC_B:    v = free_b;
      SRC_C:    v = complex_c;
      SRC_T0:   v = t0;
      SRC_T1:   v = t1;
      SRC_BIND: v = bind_r;
      SRC_UNB:  v = unb_r;
      SRC_DEB:  v = deb_r;
      SRC_DB:   v = db_r;
      SRC_DEC:  v = dec_r;
      SRC_DC:   v = dc_r;
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    alu_ctl.start = (state == S_ISSUE);
    alu_ctl.op    = uop.op;
    alu_a         = src_value(uop.sa);
    alu_b         = src_value(uop.sb);
  end

  aoe_alu #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .y    (alu_y)
  );

  aoe_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_PREP),
    .dividend (step_counter),
    .divisor  (interval_eff),
    .done     (rem_done),
    .zero     (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pc              <= '0;
      d_active        <= 1'b0;
      out_valid       <= 1'b0;
      threshold_ct    <= THRESHOLD_CT_RST;
      release_rate    <= RELEASE_RATE_RST;
      detach_rate     <= DETACH_RATE_RST;
      window_start    <= WINDOW_START_RST;
      window_end      <= WINDOW_END_RST;
      output_interval <= OUT_INTERVAL_RST;
      bind_rate       <= BIND_RATE_RST;
      unbind_rate     <= UNBIND_RATE_RST;
      cleaved_e       <= '0;
      bound_e         <= INIT_EB_C;
      free_b          <= INIT_B_C;
      complex_c       <= INIT_C_C;
      step_counter    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_THRESHOLD_CT:    threshold_ct    <= cfg_data;
          REG_RELEASE_RATE:    release_rate    <= cfg_data;
          REG_DETACH_RATE:     detach_rate     <= cfg_data;
          REG_WINDOW_START:    window_start    <= cfg_data[STEP_WIDTH-1:0];
          REG_WINDOW_END:      window_end      <= cfg_data[STEP_WIDTH-1:0];
          REG_OUTPUT_INTERVAL: output_interval <= cfg_data[STEP_WIDTH-1:0];
          REG_BIND_RATE:       bind_rate       <= cfg_data;
          REG_UNBIND_RATE:     unbind_rate     <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (reinit) begin
              cleaved_e    <= '0;
              bound_e      <= INIT_EB_C;
              free_b       <= INIT_B_C;
              complex_c    <= INIT_C_C;
              step_counter <= '0;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // empty window when start > end falls out of the two compares
          d_active <= (step_counter >= window_start) && (step_counter <= window_end);
          pc       <= '0;
          state    <= S_ISSUE;
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_done) begin
            unique case (uop.dst)
              DST_T0:   t0        <= alu_y;
              DST_T1:   t1        <= alu_y;
              DST_BIND: bind_r    <= alu_y;
              DST_UNB:  unb_r     <= alu_y;
              DST_DEB:  deb_r     <= alu_y;
              DST_DB:   db_r      <= alu_y;
              DST_DEC:  dec_r     <= alu_y;
              DST_DC:   dc_r      <= alu_y;
              DST_EC:   cleaved_e <= alu_y;
              DST_EB:   bound_e   <= alu_y;
              DST_B:    free_b    <= alu_y;
              DST_C:    complex_c <= alu_y;
              default: ;
            endcase
            unique case (uop.seq)
              SEQ_NEXT: begin
                pc    <= pc + PC_WIDTH'(1);
                state <= S_ISSUE;
              end
              SEQ_BRANCH: begin
                pc    <= release_mode ? PC_RELEASE : PC_REBIND;
                state <= S_ISSUE;
              end
              SEQ_JUMP: begin
                pc    <= PC_UPDATE;
                state <= S_ISSUE;
              end
              SEQ_END: begin
                state <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_FINISH: begin
          if (step_done) begin
            step_counter <= step_counter + STEP_WIDTH'(1);
            state        <= S_IDLE;
          end
          if (load_out) begin
            out_valid      <= 1'b1;
            step_index     <= step_counter;
            bound_amount   <= to_amount(bound_e);
            complex_amount <= to_amount(complex_c);
            cleaved_amount <= to_amount(cleaved_e);
            free_amount    <= to_amount(free_b);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AOE_ASSERT_IMPL(a_alu_done_in_wait, clk, rst, alu_done, state == S_WAIT)
  `AOE_ASSERT_IMPL(a_rem_ready_at_finish, clk, rst, state == S_FINISH, rem_done)
  `AOE_ASSERT_NEXT(a_out_from_finish, clk, rst, !out_valid && state != S_FINISH, !out_valid)
  `AOE_ASSERT_NEXT(a_step_advance, clk, rst, step_done, step_counter == $past(step_counter) + 16'd1)

endmodule

// ----- dv/adhesion_ode_euler_step_tb.sv -----
// Testbench for the adhesion Euler integrator: predicts every emitted sample and checks it.
`timescale 1ns / 1ps

module adhesion_ode_euler_step_tb;
  import aoe_pkg::*;

  localparam longint AMT_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AMT_MIN  = -AMT_MAX - 1;
  localparam longint Q_DT     = 64'sd429497;
  localparam longint Q_ET     = 64'sd429496729600;
  localparam longint Q_PT     = 64'sd1439415340;
  localparam longint Q_KM     = 64'sd42949673;
  localparam longint Q_K2     = 64'sd128849019;
  localparam longint START_EB = 64'sd429496729600;
  localparam longint START_B  = 64'sd150799312994;
  localparam longint START_C  = 64'sd1431655765;
  localparam logic [RATE_WIDTH-1:0] RATE_MAX = '1;
  localparam int DRAIN_CYCLES   = 160;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [RATE_WIDTH-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic reinit;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STEP_WIDTH-1:0] step_index;
  logic signed [AMOUNT_WIDTH-1:0] bound_amount;
  logic signed [AMOUNT_WIDTH-1:0] complex_amount;
  logic signed [AMOUNT_WIDTH-1:0] cleaved_amount;
  logic signed [AMOUNT_WIDTH-1:0] free_amount;

  adhesion_ode_euler_step dut (.*);

  typedef struct {
    logic [STEP_WIDTH-1:0]   step;
    logic [AMOUNT_WIDTH-1:0] bound;
    logic [AMOUNT_WIDTH-1:0] cplx;
    logic [AMOUNT_WIDTH-1:0] cleaved;
    logic [AMOUNT_WIDTH-1:0] free;
  } sample_t;

  sample_t pending_samples[$];
  int mismatch_count = 0;
  int send_idle_pct = 22;
  int recv_stall_pct = 52;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  // integrator state and register copy
  longint ec_q, eb_q, b_q, c_q;
  logic [STEP_WIDTH-1:0] step_count;
  longint thr_q, rel_q, det_q, kp_q, kmr_q;
  logic [STEP_WIDTH-1:0] win_lo, win_hi, emit_every;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint fx_clamp(input longint x);
    if (x > AMT_MAX) return AMT_MAX;
    if (x < AMT_MIN) return AMT_MIN;
    return x;
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return fx_clamp(a + b);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return fx_clamp(a - b);
  endfunction

  // Q16.32 product: round the magnitude half away from zero, then saturate
  function automatic longint fx_mul(input longint a, input longint b);
    logic neg;
    logic [127:0] ua, ub, mag;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    mag = (ua * ub + (128'd1 << 31)) >> 32;
    if (mag >= (128'd1 << 47)) return neg ? AMT_MIN : AMT_MAX;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic void restart_amounts();
    ec_q = 64'sd0;
    eb_q = START_EB;
    b_q = START_B;
    c_q = START_C;
    step_count = '0;
  endfunction

  function automatic void reset_model();
    thr_q = 64'sd214748364800;
    rel_q = 64'sd8589934592;
    det_q = 64'sd429496730;
    win_lo = 16'd4000;
    win_hi = 16'd8000;
    emit_every = 16'd100;
    kp_q = 64'sd429496729600;
    kmr_q = 64'sd81604378624;
    restart_amounts();
  endfunction

  function automatic void model_write(input cfg_reg_t idx, input logic [RATE_WIDTH-1:0] v);
    case (idx)
      REG_THRESHOLD_CT:    thr_q = longint'(v);
      REG_RELEASE_RATE:    rel_q = longint'(v);
      REG_DETACH_RATE:     det_q = longint'(v);
      REG_WINDOW_START:    win_lo = v[STEP_WIDTH-1:0];
      REG_WINDOW_END:      win_hi = v[STEP_WIDTH-1:0];
      REG_OUTPUT_INTERVAL: emit_every = v[STEP_WIDTH-1:0];
      REG_BIND_RATE:       kp_q = longint'(v);
      REG_UNBIND_RATE:     kmr_q = longint'(v);
      default: ;
    endcase
  endfunction

  // Advance the amounts by one Euler step; queue a sample when the interval hits.
  function automatic void integrate_step(input logic re);
    logic [STEP_WIDTH-1:0] t, every;
    longint d, bind_term, unbind_term, rel, avail, g, m, d_eb, d_b, d_ec, d_c;
    sample_t s;
    if (re) restart_amounts();
    t = step_count;
    d = (t >= win_lo && t <= win_hi) ? det_q : 64'sd0;
    bind_term = fx_mul(fx_mul(kp_q, b_q), fx_sub(Q_PT, c_q));
    unbind_term = fx_mul(kmr_q, c_q);
    if (b_q > thr_q) begin
      rel = fx_mul(fx_add(rel_q, d), eb_q);
      d_eb = fx_sub(64'sd0, rel);
      d_b = fx_add(fx_add(fx_sub(rel, bind_term), unbind_term), Q_KM);
    end else begin
      avail = fx_sub(fx_sub(Q_ET, ec_q), eb_q);
      g = fx_mul(fx_mul(Q_ET, avail), b_q);
      m = fx_mul(d, eb_q);
      d_eb = fx_sub(g, m);
      d_b = fx_add(fx_add(fx_sub(fx_add(fx_sub(64'sd0, g), m), bind_term), unbind_term), Q_KM);
    end
    d_ec = fx_mul(d, eb_q);
    d_c = fx_sub(fx_sub(bind_term, unbind_term), fx_mul(Q_K2, c_q));
    ec_q = fx_add(ec_q, fx_mul(Q_DT, d_ec));
    eb_q = fx_add(eb_q, fx_mul(Q_DT, d_eb));
    b_q = fx_add(b_q, fx_mul(Q_DT, d_b));
    c_q = fx_add(c_q, fx_mul(Q_DT, d_c));
    step_count = t + 16'd1;
    every = (emit_every == '0) ? 16'd1 : emit_every;
    if (t % every == '0) begin
      s.step = t;
      s.bound = eb_q[AMOUNT_WIDTH-1:0];
      s.cplx = c_q[AMOUNT_WIDTH-1:0];
      s.cleaved = ec_q[AMOUNT_WIDTH-1:0];
      s.free = b_q[AMOUNT_WIDTH-1:0];
      pending_samples.push_back(s);
    end
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  function automatic void compare_field(input string what, input logic [AMOUNT_WIDTH-1:0] exp,
                                        input logic [AMOUNT_WIDTH-1:0] act);
    if (exp !== act)
      flag_mismatch($sformatf("%s expected %h actual %h", what, exp, act));
  endfunction

  // sample checker
  always @(posedge clk) begin
    sample_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected word, step_index %0d", step_index));
      end else begin
        e = pending_samples.pop_front();
        compare_field("step_index", AMOUNT_WIDTH'(e.step), AMOUNT_WIDTH'(step_index));
        compare_field("bound_amount", e.bound, bound_amount);
        compare_field("complex_amount", e.cplx, complex_amount);
        compare_field("cleaved_amount", e.cleaved, cleaved_amount);
        compare_field("free_amount", e.free, free_amount);
      end
    end
  end

  // receiver: random stall, or a long hold when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_step(input logic re);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      reinit <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    reinit <= re;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    integrate_step(re);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [RATE_WIDTH-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_write(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop the input, wait for all samples, then let the last step finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [RATE_WIDTH-1:0] rand_reg_value(input cfg_reg_t r);
    logic [STEP_WIDTH-1:0] v16;
    logic [RATE_WIDTH-1:0] v;
    case (r)
      REG_WINDOW_START, REG_WINDOW_END: begin
        case ($urandom_range(7))
          0: v16 = '0;
          1: v16 = '1;
          default: v16 = step_count + 16'($urandom_range(0, (r == REG_WINDOW_END) ? 60 : 30));
        endcase
      end
      REG_OUTPUT_INTERVAL: begin
        case ($urandom_range(9))
          0: v16 = '0;
          1: v16 = '1;
          2: v16 = 16'($urandom_range(10, 100));
          default: v16 = 16'($urandom_range(1, 6));
        endcase
      end
      default: v16 = '0;
    endcase
    if (r == REG_WINDOW_START || r == REG_WINDOW_END || r == REG_OUTPUT_INTERVAL) begin
      // upper data bits are sometimes random junk for the narrow registers
      v = {($urandom_range(3) == 0) ? 31'($urandom) : 31'd0, v16};
    end else begin
      case ($urandom_range(9))
        0: v = '0;
        1: v = RATE_MAX;
        2: v = RATE_WIDTH'({$urandom, $urandom});
        default: v = {15'($urandom_range(0, (r == REG_THRESHOLD_CT) ? 60 : 150)), 32'($urandom)};
      endcase
    end
    return v;
  endfunction

  task automatic randomize_registers();
    cfg_reg_t r;
    r = r.first();
    do begin
      if ($urandom_range(1)) write_reg(r, rand_reg_value(r));
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic test_default_config();
    repeat (3) send_step(1'b0);
  endtask

  task automatic test_zero_interval();
    settle();
    write_reg(REG_OUTPUT_INTERVAL, '0);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_release_branch();
    settle();
    write_reg(REG_THRESHOLD_CT, '0);
    write_reg(REG_RELEASE_RATE, RATE_MAX);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();
    write_reg(REG_RELEASE_RATE, '0);
    send_step(1'b0);
  endtask

  task automatic test_detach_window();
    settle();
    write_reg(REG_THRESHOLD_CT, RATE_MAX);
    write_reg(REG_DETACH_RATE, {15'd5, 32'd0});
    write_reg(REG_WINDOW_START, RATE_WIDTH'(step_count + 16'd1));
    write_reg(REG_WINDOW_END, RATE_WIDTH'(step_count + 16'd2));
    repeat (4) send_step(1'b0);
    // start past end: never active
    settle();
    write_reg(REG_WINDOW_START, RATE_WIDTH'(16'hFFFF));
    write_reg(REG_WINDOW_END, '0);
    repeat (2) send_step(1'b0);
    settle();
    write_reg(REG_WINDOW_START, '0);
    write_reg(REG_WINDOW_END, RATE_WIDTH'(16'hFFFF));
    repeat (2) send_step(1'b0);
  endtask

  task automatic test_saturation();
    settle();
    write_reg(REG_BIND_RATE, RATE_MAX);
    write_reg(REG_UNBIND_RATE, RATE_MAX);
    write_reg(REG_DETACH_RATE, RATE_MAX);
    write_reg(REG_OUTPUT_INTERVAL, RATE_WIDTH'(16'hFFFF));
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    settle();
    write_reg(REG_BIND_RATE, '0);
    write_reg(REG_UNBIND_RATE, '0);
    write_reg(REG_DETACH_RATE, '0);
    write_reg(REG_OUTPUT_INTERVAL, RATE_WIDTH'(16'd1));
    send_step(1'b1);
    send_step(1'b0);
  endtask

  task automatic test_random_steps(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int chunk;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      randomize_registers();
      chunk = $urandom_range(20, 70);
      for (int i = 0; i < chunk; i++)
        send_step((i == 0) ? ($urandom_range(3) == 0) : ($urandom_range(49) == 0));
      sent += chunk;
    end
  endtask

  // hold the output for a long stretch while words keep coming
  task automatic test_output_backpressure();
    settle();
    write_reg(REG_OUTPUT_INTERVAL, RATE_WIDTH'(16'd1));
    send_idle_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    send_step(1'b1);
    repeat (11) send_step(1'b0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    reinit = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_THRESHOLD_CT;
    cfg_data = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_config();
    test_zero_interval();
    test_release_branch();
    test_detach_window();
    test_saturation();
    test_random_steps(560, 22, 52);
    test_random_steps(560, 52, 22);
    test_output_backpressure();
    test_random_steps(560, 0, 0);

    settle();
    if (mismatch_count == 0 && pending_samples.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/aoe_pkg.sv
design/aoe_alu.sv
design/aoe_rem.sv
design/adhesion_ode_euler_step.sv
dv/adhesion_ode_euler_step_tb.sv
